[src/bab_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bab_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int BYTE_BITS  = 8;
    localparam int BIT_W      = $clog2(BYTE_BITS);
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;
    localparam int MAP_BYTES  = MAX_BLOCKS / BYTE_BITS;
    localparam int ADDR_W     = BLK_W - BIT_W;
    localparam int NBYTES_W   = ADDR_W + 1;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY     = 2'd0,
        OP_MARK_USED = 2'd1,
        OP_MARK_FREE = 2'd2,
        OP_FIND_FREE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOFREE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [BLK_W-1:0] blk;
        logic             oor;
    } t_cmd;

    typedef struct packed {
        t_status          status;
        logic [BLK_W-1:0] found;
        logic             free_flag;
        logic             used_flag;
    } t_res;

endpackage
`default_nettype wire

[src/bab_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module bab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[src/bab_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module bab_front
    import bab_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clearing,
    input  wire logic [CNT_W-1:0] i_eff_count,
    input  wire logic             i_req_valid,
    output      logic             o_req_ready,
    input  wire t_op              i_req_op,
    input  wire logic [BLK_W-1:0] i_req_blk,
    output      logic             o_cmd_valid,
    output      t_cmd             o_cmd,
    input  wire logic             i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_push;
    t_cmd       w_cmd;

    // classify: range check now, so the back end only carries it out
    always_comb begin
        w_cmd.op  = i_req_op;
        w_cmd.blk = i_req_blk;
        w_cmd.oor = (i_req_op != OP_FIND_FREE) && ({1'b0, i_req_blk} >= i_eff_count);
    end

    assign o_req_ready = !i_clearing && (r_cnt != 2'd2);
    assign w_push      = i_req_valid && o_req_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end

endmodule
`default_nettype wire

[src/bab_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module bab_back
    import bab_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_eff_count,
    input  wire logic             i_cmd_valid,
    input  wire t_cmd             i_cmd,
    output      logic             o_cmd_pop,
    output      logic             o_clearing,
    output      logic             o_res_valid,
    input  wire logic             i_res_ready,
    output      t_res             o_res
);

    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_clr_addr, n_clr_addr;
    t_cmd                  r_cmd, n_cmd;
    logic [ADDR_W-1:0]     r_byte, n_byte;
    logic [NBYTES_W-1:0]   r_tries, n_tries;
    logic [BLK_W-1:0]      r_hint, n_hint;
    t_res                  r_res, n_res;
    t_res                  r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  w_we;
    logic [ADDR_W-1:0]     w_waddr, w_raddr;
    logic [BYTE_BITS-1:0]  w_wdata, w_rdata, w_mask;
    logic [CNT_W:0]        w_sum;
    logic [NBYTES_W-1:0]   w_nbytes, w_byte_inc, w_tries_inc;
    logic [ADDR_W-1:0]     w_start_byte, w_next_byte;
    logic                  w_last_try, w_hit, w_out_free;
    logic [BIT_W-1:0]      w_hit_bit;
    logic [BLK_W-1:0]      w_cand;
    logic [CNT_W-1:0]      w_cand_inc;

    bab_ram #(
        .WIDTH(BYTE_BITS),
        .DEPTH(MAP_BYTES)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_sum        = {1'b0, i_eff_count} + (CNT_W + 1)'(BYTE_BITS - 1);
    assign w_nbytes     = w_sum[CNT_W-1:BIT_W];
    assign w_start_byte = ({1'b0, r_hint} < i_eff_count) ? r_hint[BLK_W-1:BIT_W] : '0;
    assign w_byte_inc   = {1'b0, r_byte} + NBYTES_W'(1);
    assign w_next_byte  = (w_byte_inc == w_nbytes) ? '0 : w_byte_inc[ADDR_W-1:0];
    assign w_tries_inc  = r_tries + NBYTES_W'(1);
    assign w_last_try   = (w_tries_inc == w_nbytes);
    assign w_mask       = BYTE_BITS'(1) << r_cmd.blk[BIT_W-1:0];
    assign w_out_free   = !r_out_valid || i_res_ready;
    assign w_cand       = {r_byte, w_hit_bit};
    assign w_cand_inc   = {1'b0, w_cand} + CNT_W'(1);

    // lowest clear bit of the fetched byte that lies below the block count
    always_comb begin
        w_hit     = 1'b0;
        w_hit_bit = '0;
        for (int b = 0; b < BYTE_BITS; b++) begin
            if (!w_hit && !w_rdata[b] && ({1'b0, r_byte, BIT_W'(b)} < i_eff_count)) begin
                w_hit     = 1'b1;
                w_hit_bit = BIT_W'(b);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(MAP_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.oor) begin
                        n_state = S_DONE;
                    end else if (i_cmd.op == OP_FIND_FREE) begin
                        n_state = (i_eff_count == '0) ? S_DONE : S_SCAN;
                    end else begin
                        n_state = S_ACCESS;
                    end
                end
            end
            S_ACCESS: n_state = S_DONE;
            S_SCAN: begin
                if (w_hit || w_last_try) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_clr_addr  = r_clr_addr;
        n_cmd       = r_cmd;
        n_byte      = r_byte;
        n_tries     = r_tries;
        n_hint      = r_hint;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_cmd.blk[BLK_W-1:BIT_W];
        w_wdata     = w_rdata;
        w_raddr     = i_cmd.blk[BLK_W-1:BIT_W];
        unique case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_res     = '0;
                    n_byte    = w_start_byte;
                    n_tries   = '0;
                    if (i_cmd.oor) begin
                        n_res.status = ST_RANGE;
                    end else if (i_cmd.op == OP_FIND_FREE) begin
                        w_raddr = w_start_byte;
                        if (i_eff_count == '0) begin
                            n_res.status = ST_NOFREE;
                        end
                    end
                end
            end
            S_ACCESS: begin
                unique case (r_cmd.op)
                    OP_QUERY: begin
                        n_res.used_flag = w_rdata[r_cmd.blk[BIT_W-1:0]];
                        n_res.free_flag = !w_rdata[r_cmd.blk[BIT_W-1:0]];
                    end
                    OP_MARK_USED: begin
                        w_we    = 1'b1;
                        w_wdata = w_rdata | w_mask;
                    end
                    OP_MARK_FREE: begin
                        w_we    = 1'b1;
                        w_wdata = w_rdata & ~w_mask;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_res.found  = w_cand;
                    n_res.status = ST_OK;
                    n_hint       = (w_cand_inc == i_eff_count) ? '0 : w_cand_inc[BLK_W-1:0];
                end else if (w_last_try) begin
                    n_res.status = ST_NOFREE;
                end else begin
                    n_byte  = w_next_byte;
                    n_tries = w_tries_inc;
                    w_raddr = w_next_byte;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_byte  <= n_byte;
        r_tries <= n_tries;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule
`default_nettype wire

[src/block_allocation_bitmap.sv]
// Channel    Direction  Handshake                      Payload
// request    in         s_axis_tvalid / s_axis_tready  tuser: op; tdata: block_number
// result     out        m_axis_tvalid / m_axis_tready  tdata: used, free, found, status
// config     in         i_cfg_valid / o_cfg_ready      i_cfg_data: block_count
//
// Back end steps: query and mark go read, access, result; an out-of-range block
// skips the access; find-free visits the bitmap bytes one at a time, up to
// (block_count + 7) / 8 of them, as the bitmap RAM has a single read port.
// After reset all 512 bytes of the RAM are swept clear, one byte a cycle, with
// s_axis_tready low; configuration writes are taken throughout.
// A two-entry queue parts intake from the back end; the result register lets
// the next request start while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
module block_allocation_bitmap
    import bab_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration write: block_count
    input  wire logic             i_cfg_valid,
    output      logic             o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data,
    // request stream
    input  wire logic             s_axis_tvalid,
    output      logic             s_axis_tready,
    input  wire logic [15:0]      s_axis_tdata,   // [11:0] block_number
    input  wire logic [1:0]       s_axis_tuser,   // [1:0] op
    // result stream
    output      logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output      logic [15:0]      m_axis_tdata    // [0] used_flag, [1] free_flag,
                                                  // [13:2] found_block, [15:14] status
);

    logic [CNT_W-1:0] r_eff_count;
    logic             w_cmd_valid, w_cmd_pop, w_clearing;
    t_cmd             w_cmd;
    t_res             w_res;

    // hold the count clipped to the bitmap size, so every user sees the effective value
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_count <= CNT_W'(MAX_BLOCKS);
        end else if (i_cfg_valid) begin
            r_eff_count <= (i_cfg_data > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : i_cfg_data;
        end
    end

    // front end: take requests, flag out-of-range blocks, queue them
    bab_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clearing (w_clearing),
        .i_eff_count(r_eff_count),
        .i_req_valid(s_axis_tvalid),
        .o_req_ready(s_axis_tready),
        .i_req_op   (t_op'(s_axis_tuser)),
        .i_req_blk  (s_axis_tdata[BLK_W-1:0]),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    // back end: bitmap RAM, next-free hint and the scan sequencer
    bab_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_eff_count(r_eff_count),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .o_clearing (w_clearing),
        .o_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready),
        .o_res      (w_res)
    );

    // pack the result: used flag lowest, status highest
    assign m_axis_tdata = {w_res.status, w_res.found, w_res.free_flag, w_res.used_flag};

endmodule
`default_nettype wire

[src/bab_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module bab_checker
    import bab_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    logic w_flag_any, w_found_any, w_ok;

    assign w_flag_any  = m_axis_tdata[0] || m_axis_tdata[1];
    assign w_found_any = (m_axis_tdata[13:2] != '0);
    assign w_ok        = (m_axis_tdata[15:14] == ST_OK);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:14] == ST_OK) || (m_axis_tdata[15:14] == ST_RANGE)
                          || (m_axis_tdata[15:14] == ST_NOFREE))
        else $error("undefined status");

    a_query_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_flag_any |-> w_ok && !w_found_any
                                         && (m_axis_tdata[0] != m_axis_tdata[1]))
        else $error("query flags inconsistent");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_found_any |-> w_ok && !w_flag_any)
        else $error("found block with bad status or flags");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("channels active straight after reset");

endmodule

bind block_allocation_bitmap bab_checker u_bab_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import bab_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 125;
    localparam int RANDOM_PHASES = 10;

    // Predicts the bitmap allocator: one used bit per block, the next-fit hint and
    // the programmed count, plus the queue of results still to come.
    class alloc_scoreboard;
        bit               used_map [MAX_BLOCKS];
        int unsigned      next_hint;
        int unsigned      block_count;
        int unsigned      last_found;
        bit               last_find_ok;
        t_res             pending_results [$];
        int               mismatches;

        function new();
            foreach (used_map[i]) used_map[i] = 1'b0;
            next_hint    = 0;
            block_count  = MAX_BLOCKS;
            last_found   = 0;
            last_find_ok = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_block_count(logic [CNT_W-1:0] value);
            block_count = 32'(value);
        endfunction

        function int unsigned tracked_blocks();
            return (block_count > MAX_BLOCKS) ? MAX_BLOCKS : block_count;
        endfunction

        // Work out the result of one accepted request and update the bitmap.
        function void predict_request(t_op op, logic [BLK_W-1:0] blk);
            t_res        res;
            int unsigned span, nbytes, byte_no, tries, bit_no, cand;
            bit          hit;
            span = tracked_blocks();
            res = '0;
            if (op == OP_FIND_FREE) begin
                nbytes = (span + BYTE_BITS - 1) / BYTE_BITS;
                byte_no = (next_hint < span) ? next_hint / BYTE_BITS : 0;
                res.status = ST_NOFREE;
                hit = 1'b0;
                tries = 0;
                // full bytes fall through the inner loop without a hit
                while (tries < nbytes && !hit) begin
                    bit_no = 0;
                    while (bit_no < BYTE_BITS && !hit &&
                           byte_no * BYTE_BITS + bit_no < span) begin
                        cand = byte_no * BYTE_BITS + bit_no;
                        if (!used_map[cand]) begin
                            hit = 1'b1;
                            res.found = cand[BLK_W-1:0];
                            res.status = ST_OK;
                            next_hint = (cand + 1) % span;
                            last_found = cand;
                        end
                        bit_no++;
                    end
                    if (!hit)
                        byte_no = (byte_no + 1) % nbytes;
                    tries++;
                end
                last_find_ok = hit;
            end else if (blk >= span) begin
                res.status = ST_RANGE;
            end else begin
                case (op)
                    OP_QUERY: begin
                        res.used_flag = used_map[blk];
                        res.free_flag = !used_map[blk];
                    end
                    OP_MARK_USED: used_map[blk] = 1'b1;
                    default:      used_map[blk] = 1'b0;
                endcase
            end
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(logic [15:0] data);
            t_res got, want;
            got = t_res'(data);
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: used %0b free %0b found %0d status %0d",
                             got.used_flag, got.free_flag, got.found, got.status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.used_flag !== want.used_flag || got.free_flag !== want.free_flag ||
                    got.found !== want.found || got.status !== want.status) begin
                    if (mismatches < 10) begin
                        $write("result mismatch: expected used %0b free %0b found %0d status %0d, ",
                               want.used_flag, want.free_flag, want.found, want.status);
                        $display("got used %0b free %0b found %0d status %0d",
                                 got.used_flag, got.free_flag, got.found, got.status);
                    end
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [15:0]      s_axis_tdata;
    logic [1:0]       s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [15:0]      m_axis_tdata;

    alloc_scoreboard sb;
    bit              steady_flow;
    bit              hold_off_start;
    int              stall_left;
    int              quiet_cycles;

    block_allocation_bitmap uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one request at the falling edge and hold it until taken.
    task automatic issue_request(input t_op op, input logic [BLK_W-1:0] blk);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {4'b0000, blk};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.predict_request(op, blk);
        @(negedge i_clk);
    endtask

    task automatic write_block_count(input logic [CNT_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_block_count(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_off_start) begin
            hold_off_start = 1'b0;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else begin
            m_axis_tready = 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Watchdog: end the run when nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CNT_W-1:0] phase_counts [RANDOM_PHASES];
        int               phase, sent, r;
        int unsigned      span;
        t_op              op;
        logic [BLK_W-1:0] blk;

        sb = new();
        steady_flow = 1'b0;
        hold_off_start = 1'b0;
        stall_left = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes at the full count.
        issue_request(OP_QUERY, 12'd0);
        issue_request(OP_QUERY, 12'd4095);
        issue_request(OP_MARK_USED, 12'd0);
        issue_request(OP_MARK_USED, 12'd4095);
        issue_request(OP_QUERY, 12'd0);
        issue_request(OP_QUERY, 12'd4095);
        issue_request(OP_FIND_FREE, 12'd0);
        issue_request(OP_FIND_FREE, 12'd4095);
        issue_request(OP_MARK_FREE, 12'd0);
        issue_request(OP_QUERY, 12'd0);
        drain_results();

        // Lower the count below the hint: the scan restarts at byte zero.
        write_block_count(13'd3);
        issue_request(OP_QUERY, 12'd3);
        issue_request(OP_MARK_USED, 12'd4095);
        issue_request(OP_FIND_FREE, 12'd0);
        issue_request(OP_MARK_USED, 12'd0);
        issue_request(OP_MARK_USED, 12'd1);
        issue_request(OP_MARK_USED, 12'd2);
        issue_request(OP_FIND_FREE, 12'd0);
        issue_request(OP_MARK_FREE, 12'd2);
        issue_request(OP_FIND_FREE, 12'd0);
        drain_results();

        // Count of zero: nothing is in range.
        write_block_count(13'd0);
        issue_request(OP_FIND_FREE, 12'd0);
        issue_request(OP_QUERY, 12'd0);
        issue_request(OP_MARK_FREE, 12'd0);
        drain_results();

        // Count above the maximum behaves as the maximum.
        write_block_count(13'h1FFF);
        issue_request(OP_QUERY, 12'd4095);
        issue_request(OP_FIND_FREE, 12'd0);
        issue_request(OP_MARK_FREE, 12'd4095);
        drain_results();

        phase_counts[0] = 13'd4096;
        phase_counts[1] = 13'd1;
        phase_counts[2] = 13'd8;
        phase_counts[3] = 13'd9;
        phase_counts[4] = 13'd37;
        phase_counts[5] = CNT_W'($urandom_range(2, 64));
        phase_counts[6] = 13'd4095;
        phase_counts[7] = CNT_W'($urandom_range(65, 700));
        phase_counts[8] = 13'd16;
        phase_counts[9] = CNT_W'($urandom_range(1, 4096));

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_block_count(phase_counts[phase]);
            steady_flow = (phase == 4 || phase == 6);
            // let the block fill up and back-pressure its input
            if (phase == 2)
                hold_off_start = 1'b1;
            span = sb.tracked_blocks();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    // allocate: find a free block, then claim it
                    issue_request(OP_FIND_FREE, BLK_W'($urandom));
                    sent++;
                    if (sb.last_find_ok) begin
                        issue_request(OP_MARK_USED, BLK_W'(sb.last_found));
                        sent++;
                    end
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 25)
                        op = OP_QUERY;
                    else if (r < 55)
                        op = OP_MARK_USED;
                    else if (r < 80)
                        op = OP_MARK_FREE;
                    else
                        op = OP_FIND_FREE;
                    if (span == 0 || $urandom_range(0, 9) == 0)
                        blk = BLK_W'($urandom);
                    else
                        blk = BLK_W'($urandom_range(0, span - 1));
                    issue_request(op, blk);
                    sent++;
                end
            end
            drain_results();
        end

        steady_flow = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[block_allocation_bitmap.f]
src/bab_pkg.sv
src/bab_ram.sv
src/bab_front.sv
src/bab_back.sv
src/block_allocation_bitmap.sv
src/bab_checker.sv
test/testbench.sv
